@@ rtl/core/rkrf_pkg.sv @@
// Shared types and constants of the remote key repeat filter.
package rkrf_pkg;

  localparam int unsigned LenW     = 6;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned TallyW   = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 8;

  localparam logic [LenW-1:0]   ReportLen    = 6'd6;
  localparam logic [ByteW-1:0]  HeaderValue  = 8'h00;
  localparam logic [ByteW-1:0]  SizeValue    = 8'h06;
  localparam logic [ByteW-1:0]  TrailerValue = 8'h0A;
  localparam logic [TallyW-1:0] TallyMinPass = 3'd5;
  localparam logic [TallyW-1:0] TallyMax     = 3'd7;
  localparam logic [CfgW-1:0]   FilterReset  = 16'd300;
  localparam logic [CfgW-1:0]   DelayReset   = 16'd500;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FILTER_WINDOW = 2'd0,
    CFG_REPEAT_DELAY  = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic [ByteW-1:0] trailer_byte;
    logic [ByteW-1:0] key_byte;
    logic [ByteW-1:0] size_byte;
    logic [ByteW-1:0] header_byte;
    logic [LenW-1:0]  report_length;
  } report_t;

  typedef struct packed {
    logic             is_repeat;
    logic [ByteW-1:0] key_code;
  } result_t;

endpackage

@@ rtl/core/rkrf_in_stage.sv @@
// Input register that holds one accepted report for the filter core.
module rkrf_in_stage
  import rkrf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  report_t data_i,
  output logic    valid_o,
  input  logic    ready_i,
  output report_t data_o
);

  logic    valid_q, valid_d;
  report_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ready_o) begin
      valid_d = valid_i;
      data_d  = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

@@ rtl/core/rkrf_core.sv @@
// Report check, repeat tracking state, decision logic and setting registers.
module rkrf_core
  import rkrf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  report_t             data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output result_t             data_o
);

  logic [CfgW-1:0]   filter_q, filter_d;
  logic [CfgW-1:0]   delay_q, delay_d;
  logic [ByteW-1:0]  last_key_q, last_key_d;
  logic [TimeW-1:0]  start_q, start_d;
  logic [TallyW-1:0] tally_q, tally_d;

  logic              well_formed;
  logic              is_repeat;
  logic              suppress;
  logic              has_result;
  logic              fire;
  logic [TallyW-1:0] tally_next;
  logic [TimeW-1:0]  filter_end;
  logic [TimeW-1:0]  delay_end;
  logic [TimeW-1:0]  filter_diff;
  logic [TimeW-1:0]  delay_diff;

  assign well_formed = (data_i.report_length == ReportLen) &&
                       (data_i.header_byte == HeaderValue) &&
                       (data_i.size_byte == SizeValue) &&
                       (data_i.trailer_byte == TrailerValue);

  assign filter_end  = start_q + {{(TimeW-CfgW){1'b0}}, filter_q};
  assign delay_end   = start_q + {{(TimeW-CfgW){1'b0}}, delay_q};
  assign filter_diff = data_i.now_ms - filter_end;
  assign delay_diff  = data_i.now_ms - delay_end;

  assign is_repeat  = (data_i.key_byte == last_key_q) && filter_diff[TimeW-1];
  assign tally_next = !is_repeat ? '0 :
                      (tally_q == TallyMax) ? tally_q : tally_q + 1'b1;

  // A fresh press clears the tally, so only a repeat can be held back.
  assign suppress   = (tally_next != '0) &&
                      ((tally_next < TallyMinPass) || delay_diff[TimeW-1]);
  assign has_result = well_formed && !suppress;

  assign ready_o          = !has_result || ready_i;
  assign fire             = valid_i && ready_o;
  assign valid_o          = valid_i && has_result;
  assign data_o.key_code  = data_i.key_byte;
  assign data_o.is_repeat = (tally_next != '0);

  always_comb begin
    last_key_d = last_key_q;
    start_d    = start_q;
    tally_d    = tally_q;
    if (fire && well_formed) begin
      tally_d = tally_next;
      if (!is_repeat) begin
        last_key_d = data_i.key_byte;
        start_d    = data_i.now_ms;
      end
    end
  end

  always_comb begin
    filter_d = filter_q;
    delay_d  = delay_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FILTER_WINDOW: filter_d = cfg_data_i;
        CFG_REPEAT_DELAY:  delay_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q   <= FilterReset;
      delay_q    <= DelayReset;
      last_key_q <= '0;
      start_q    <= '0;
      tally_q    <= '0;
    end else begin
      filter_q   <= filter_d;
      delay_q    <= delay_d;
      last_key_q <= last_key_d;
      start_q    <= start_d;
      tally_q    <= tally_d;
    end
  end

endmodule

@@ rtl/core/rkrf_out_stage.sv @@
// Result register with a skid entry that absorbs one result while the receiver stalls.
module rkrf_out_stage
  import rkrf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  result_t data_i,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || ready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = valid_i;
        out_d       = data_i;
      end
    end else if (valid_i && !skid_valid_q) begin
      skid_valid_d = 1'b1;
      skid_d       = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

@@ rtl/core/remote_key_repeat_filter.sv @@
// Top level of the remote key repeat filter.
//
// Reports arrive on the s_axis channel, one per transfer, and keys that pass
// the filter leave on the m_axis channel with the repeat flag in m_axis_tuser.
// Malformed reports and held-back repeats produce no output transfer.
// The two settings are written on the cfg channel, which is always ready;
// index 0 is the filter window and index 1 the repeat delay, both in ms.
// Writes to other indexes are ignored. The user must ensure settings are changed
// only while idle; the block itself does not enforce this. A report is registered
// in the input register on acceptance, then decided against the repeat state
// and written to the result register. One report is taken every cycle unless
// the receiver stalls; the repeat state updates when the report is decided.
// When the receiver stalls, the result register plus one skid entry absorb
// results; a further report that yields a key then waits in the input
// register and s_axis_tready falls until the receiver drains them.
// Reset clears the repeat state to code 0, window start 0 and tally 0, and
// loads the window and delay defaults of 300 and 500 ms.
module remote_key_repeat_filter
  import rkrf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // report_length, header_byte, size_byte, key_byte, trailer_byte, now_ms, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // key_code
  output logic [OutDataW-1:0] m_axis_tdata,
  // is_repeat
  output logic                m_axis_tuser,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  report_t in_report;
  report_t stage_report;
  logic    stage_valid;
  logic    stage_ready;
  result_t core_result;
  logic    core_valid;
  logic    core_ready;
  result_t out_result;

  assign in_report   = report_t'(s_axis_tdata[$bits(report_t)-1:0]);
  assign cfg_ready_o = 1'b1;

  rkrf_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (in_report),
    .valid_o (stage_valid),
    .ready_i (stage_ready),
    .data_o  (stage_report)
  );

  rkrf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .valid_i     (stage_valid),
    .ready_o     (stage_ready),
    .data_i      (stage_report),
    .valid_o     (core_valid),
    .ready_i     (core_ready),
    .data_o      (core_result)
  );

  rkrf_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (core_valid),
    .ready_o (core_ready),
    .data_i  (core_result),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_result)
  );

  assign m_axis_tdata = out_result.key_code;
  assign m_axis_tuser = out_result.is_repeat;

endmodule
